// ===== design/nfsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nearest free site assigner.
// Used by the controller, the datapath and the top level; depends on nothing.
package nfsa_pkg;

   localparam int SITE_SLOTS = 16;
   localparam int IDX_W      = (SITE_SLOTS > 1) ? $clog2(SITE_SLOTS) : 1;

   localparam int SLOT_W = 4;
   localparam int ID_W   = 16;
   localparam int POS_W  = 9;
   localparam int FREE_W = 16;
   localparam int STAT_W = 2;
   localparam int DIST_W = 9;

   // squared distance and square root widths
   localparam int SQ_W   = 2 * POS_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int RAD_W  = SUM_W + (SUM_W % 2);
   localparam int ROOT_W = RAD_W / 2;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_PLACE = 1'b1
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_LOADED = 2'd0,
      STATUS_PLACED = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [ID_W-1:0]     site_id;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [FREE_W-1:0]   free_count;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     chosen_id;
      logic [SLOT_W-1:0]   chosen_slot;
      logic [DIST_W-1:0]   distance;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load;
      logic scan_init;
      logic read;
      logic square;
      logic sum;
      logic root_step;
      logic compare;
      logic advance;
      logic commit;
      logic present;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_place;
      logic entry_live;
      logic root_last;
      logic scan_last;
   } stat_type;

endpackage

// ===== design/nfsa_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the nearest free site assigner: site table, distance unit with a
// bit-serial square root, best-site tracking and result registers. Uses nfsa_pkg.
module nfsa_datapath import nfsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  req_type  req_data,
   output stat_type stat,
   output rsp_type  rsp_data
);

   req_type             req_ff;

   logic [SITE_SLOTS-1:0] valid_ff;
   logic [ID_W-1:0]     mem_id   [SITE_SLOTS];
   logic [POS_W-1:0]    mem_x    [SITE_SLOTS];
   logic [POS_W-1:0]    mem_y    [SITE_SLOTS];
   logic [FREE_W-1:0]   mem_free [SITE_SLOTS];

   logic [IDX_W-1:0]    idx_ff;
   logic                rd_valid_ff;
   logic [ID_W-1:0]     rd_id_ff;
   logic [POS_W-1:0]    rd_x_ff;
   logic [POS_W-1:0]    rd_y_ff;
   logic [FREE_W-1:0]   rd_free_ff;

   logic [SQ_W-1:0]     dx2_ff;
   logic [SQ_W-1:0]     dy2_ff;
   logic [RAD_W-1:0]    rem_ff;
   logic [RAD_W-1:0]    root_ff;
   logic [RAD_W-1:0]    bit_ff;

   logic                found_ff;
   logic [ROOT_W-1:0]   best_dist_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [ID_W-1:0]     best_id_ff;
   logic [FREE_W-1:0]   best_free_ff;

   rsp_type             res_ff;
   rsp_type             rsp_ff;

   logic                load_ok;
   logic [IDX_W-1:0]    load_addr;
   logic [POS_W-1:0]    dx;
   logic [POS_W-1:0]    dy;
   logic [RAD_W-1:0]    trial;
   logic [ROOT_W-1:0]   cur_dist;
   logic [DIST_W-1:0]   dist_sat;

   assign load_ok   = (32'(req_ff.slot) < 32'(SITE_SLOTS));
   assign load_addr = IDX_W'(req_ff.slot);

   assign dx = (rd_x_ff >= req_ff.pos_x) ? rd_x_ff - req_ff.pos_x : req_ff.pos_x - rd_x_ff;
   assign dy = (rd_y_ff >= req_ff.pos_y) ? rd_y_ff - req_ff.pos_y : req_ff.pos_y - rd_y_ff;

   assign trial    = root_ff + bit_ff;
   assign cur_dist = root_ff[ROOT_W-1:0];

   // reported distance saturates; comparison uses the full root
   assign dist_sat = (best_dist_ff > ROOT_W'((1 << DIST_W) - 1)) ? '1
                                                                : DIST_W'(best_dist_ff);

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.load && load_ok) begin
         valid_ff[load_addr] <= 1'b1;
      end
   end

   // site table: one write port, one registered read port at the scan index
   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         mem_id[load_addr]   <= req_ff.site_id;
         mem_x[load_addr]    <= req_ff.pos_x;
         mem_y[load_addr]    <= req_ff.pos_y;
         mem_free[load_addr] <= req_ff.free_count;
      end else if (cmd.commit && found_ff) begin
         mem_free[best_idx_ff] <= best_free_ff - FREE_W'(1);
      end
      if (cmd.read) begin
         rd_valid_ff <= valid_ff[idx_ff];
         rd_id_ff    <= mem_id[idx_ff];
         rd_x_ff     <= mem_x[idx_ff];
         rd_y_ff     <= mem_y[idx_ff];
         rd_free_ff  <= mem_free[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         idx_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // squares, sum, then one trial bit of the root per cycle
   always_ff @(posedge clock) begin
      if (cmd.square) begin
         dx2_ff <= SQ_W'(dx) * SQ_W'(dx);
         dy2_ff <= SQ_W'(dy) * SQ_W'(dy);
      end
      if (cmd.sum) begin
         rem_ff  <= RAD_W'(dx2_ff) + RAD_W'(dy2_ff);
         root_ff <= '0;
         bit_ff  <= RAD_W'(1) << (RAD_W - 2);
      end else if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // best site so far; strict less keeps the lowest slot on ties
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         found_ff <= 1'b0;
      end else if (cmd.compare && (!found_ff || cur_dist < best_dist_ff)) begin
         found_ff <= 1'b1;
      end
      if (cmd.compare && (!found_ff || cur_dist < best_dist_ff)) begin
         best_dist_ff <= cur_dist;
         best_idx_ff  <= idx_ff;
         best_id_ff   <= rd_id_ff;
         best_free_ff <= rd_free_ff;
      end
   end

   // pending result, then output register once the previous beat is gone
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff <= '{status: STATUS_LOADED, chosen_id: '0, chosen_slot: '0, distance: '0};
      end else if (cmd.commit) begin
         if (found_ff) begin
            res_ff <= '{status: STATUS_PLACED, chosen_id: best_id_ff,
                        chosen_slot: SLOT_W'(best_idx_ff), distance: dist_sat};
         end else begin
            res_ff <= '{status: STATUS_FULL, chosen_id: '0, chosen_slot: '0, distance: '0};
         end
      end
      if (cmd.present) begin
         rsp_ff <= res_ff;
      end
   end

   assign stat.op_place   = (req_ff.op == OP_PLACE);
   assign stat.entry_live = rd_valid_ff && (rd_free_ff != '0);
   assign stat.root_last  = bit_ff[0];
   assign stat.scan_last  = (idx_ff == IDX_W'(SITE_SLOTS - 1));

   assign rsp_data = rsp_ff;

endmodule

// ===== design/nfsa_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the nearest free site assigner: sequences load, scan, root
// iterations and result hand-off, and owns the response valid. Uses nfsa_pkg.
module nfsa_ctrl import nfsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ,
      S_CHECK,
      S_SUM,
      S_ROOT,
      S_CMP,
      S_FINISH,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.op_place) begin
               cmd.scan_init = 1'b1;
               state_in      = S_READ;
            end else begin
               cmd.load = 1'b1;
               state_in = S_OUT;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.entry_live) begin
               cmd.square = 1'b1;
               state_in   = S_SUM;
            end else if (stat.scan_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (stat.root_last) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            if (stat.scan_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_FINISH: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.present = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.present ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/nearest_free_site_assigner.sv =====
`timescale 1ns / 1ps
// A load beat is captured, dispatched and handed off. A request beat scans all
// 16 slots in order: a slot that is empty or has no free capacity is read and
// skipped, a live slot passes through table read, squares, sum, ten steps of the
// bit-serial square root and compare, with the one square root unit shared by all
// slots; capture, dispatch and result hand-off come on top. Hand-off also waits for
// as long as the previous result is stalled. One beat is worked on at a time; a
// finished result waits in the output register while the next beat enters.
// Depends on nfsa_pkg, nfsa_ctrl and nfsa_datapath.
module nearest_free_site_assigner import nfsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   nfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   nfsa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // a beat once taken blocks the input until its work is done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while a beat is in work");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_LOADED || rsp_data.status == STATUS_FULL))
      |-> (rsp_data.chosen_id == '0 && rsp_data.chosen_slot == '0
           && rsp_data.distance == '0))
      else $error("nonzero fields on a load or full result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_LOADED || rsp_data.status == STATUS_PLACED
                     || rsp_data.status == STATUS_FULL))
      else $error("bad result status");

endmodule
